### design/tscd_pkg.sv
// Package for the thumb-shift chord detector: codes, field widths and types.
// Used by the channel interfaces, the top level and the checker.
package tscd_pkg;

    localparam int ModeW = 3;
    localparam int KeyW  = 16;
    localparam int TimeW = 32;
    localparam int ModW  = 8;
    localparam int KindW = 2;
    localparam int WaitW = 10;
    localparam int IdW   = 8;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 10;

    // HID shift bits: left shift is bit 1, right shift is bit 5.
    localparam logic [ModW-1:0] ShiftMask = 8'h22;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_CHAR_WAIT  = 3'd0,
        CFG_THUMB_WAIT = 3'd1,
        CFG_OVERLAP    = 3'd2,
        CFG_DEDICATED  = 3'd3,
        CFG_US_LAYOUT  = 3'd4,
        CFG_LEFT_ID    = 3'd5,
        CFG_RIGHT_ID   = 3'd6
    } t_cfg_idx;

    typedef enum logic [ModeW-1:0] {
        EV_INIT    = 3'd0,
        EV_ALLOFF  = 3'd1,
        EV_CHAR    = 3'd2,
        EV_THUMB   = 3'd3,
        EV_RELEASE = 3'd4,
        EV_TICK    = 3'd5
    } t_event;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_CHAR       = 3'd1,
        PH_THUMB      = 3'd2,
        PH_CHAR_THUMB = 3'd3,
        PH_THUMB_CHAR = 3'd4
    } t_phase;

    typedef enum logic [KindW-1:0] {
        KIND_STROKE     = 2'd0,
        KIND_THUMB      = 2'd1,
        KIND_LEFT_LONG  = 2'd2,
        KIND_RIGHT_LONG = 2'd3
    } t_kind;

    // Which pending keys go into the emitted stroke.
    typedef enum logic [2:0] {
        EM_NONE,
        EM_FULL,
        EM_NO_THUMB,
        EM_NO_CHAR,
        EM_LONG
    } t_emit;

endpackage

### design/tscd_in_if.sv
// Event channel of the thumb-shift chord detector: valid, ready and one event.
// Depends on tscd_pkg for the field widths.
interface tscd_in_if;
    import tscd_pkg::*;

    logic              valid;
    logic              ready;
    logic [ModeW-1:0]  mode;
    logic [KeyW-1:0]   key;
    logic [TimeW-1:0]  time_ms;
    logic [ModW-1:0]   modifiers;

    modport source (output valid, mode, key, time_ms, modifiers, input ready);
    modport sink   (input valid, mode, key, time_ms, modifiers, output ready);
endinterface

### design/tscd_out_if.sv
// Result channel of the thumb-shift chord detector: valid, ready and one stroke.
// Depends on tscd_pkg for the field widths.
interface tscd_out_if;
    import tscd_pkg::*;

    logic              valid;
    logic              ready;
    logic [KindW-1:0]  kind;
    logic [KeyW-1:0]   char_key;
    logic [KeyW-1:0]   thumb_key;
    logic              shift_as_thumb;
    logic [ModW-1:0]   held_modifiers;

    modport source (output valid, kind, char_key, thumb_key, shift_as_thumb,
                    held_modifiers, input ready);
    modport sink   (input valid, kind, char_key, thumb_key, shift_as_thumb,
                    held_modifiers, output ready);
endinterface

### design/thumb_shift_chord_detector.sv
// Thumb-shift chord detector top level: event register, decision logic, result register.
// Depends on tscd_pkg, tscd_in_if and tscd_out_if.
//
//  Channel   Direction  Carries                                  Transfer when
//  i_ev      in         mode, key, time_ms, modifiers            valid && ready
//  o_res     out        kind, char_key, thumb_key, shift, mods   valid && ready
//  i_cfg_*   in         register index and write data            i_cfg_we high
//
// An event goes from its transfer on i_ev into the event register, then through
// the decision logic into the result register, which drives o_res. One event per
// cycle is sustained while o_res does not stall; the phase and pending-key
// registers update once for each event that the decision stage takes.
// Reset is synchronous and active low; it returns the configuration and detector
// state registers to their default values and empties both pipeline registers.
// When o_res stalls, the event register holds and i_ev drops ready only once
// both the event register and the result register are full.
module thumb_shift_chord_detector (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tscd_in_if.sink                         i_ev,
    tscd_out_if.source                      o_res,
    input  logic                            i_cfg_we,
    input  logic [tscd_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [tscd_pkg::CfgDataW-1:0]   i_cfg_data
);
    import tscd_pkg::*;

    // Configuration registers.
    logic [WaitW-1:0] r_char_wait;
    logic [WaitW-1:0] r_thumb_wait;
    logic [WaitW-1:0] r_overlap;
    logic             r_dedicated;
    logic             r_us_layout;
    logic [IdW-1:0]   r_left_id;
    logic [IdW-1:0]   r_right_id;

    // Event register.
    logic             r_in_valid;
    logic [ModeW-1:0] r_mode;
    logic [KeyW-1:0]  r_key;
    logic [TimeW-1:0] r_now;
    logic [ModW-1:0]  r_mods;

    // Detector state.
    t_phase           r_phase, n_phase;
    logic [KeyW-1:0]  r_pc, n_pc;
    logic [KeyW-1:0]  r_pt, n_pt;
    logic [TimeW-1:0] r_ctime, n_ctime;
    logic [TimeW-1:0] r_ttime, n_ttime;
    logic [TimeW-1:0] r_dl, n_dl;

    // Result register.
    logic             r_out_valid;
    t_kind            r_kind, n_kind;
    logic [KeyW-1:0]  r_out_c, n_out_c;
    logic [KeyW-1:0]  r_out_t, n_out_t;
    logic             r_out_s, n_out_s;
    logic [ModW-1:0]  r_out_mods;
    logic             n_out_valid;

    logic             fire;
    t_event           ev;
    logic             tick_hit;
    logic             ev_ok;
    logic [TimeW-1:0] t1, t2, ref_time;
    logic             t1_lt_t2;
    logic             split_ok;
    t_emit            emit_sel;
    logic [KeyW-1:0]  eff_c, eff_t;

    // The decision stage runs whenever it holds an event and the result
    // register is free or being emptied in this cycle.
    assign fire        = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_ev.ready  = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_wait  <= WaitW'(100);
            r_thumb_wait <= WaitW'(100);
            r_overlap    <= WaitW'(50);
            r_dedicated  <= 1'b0;
            r_us_layout  <= 1'b0;
            r_left_id    <= '0;
            r_right_id   <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_CHAR_WAIT:  r_char_wait  <= i_cfg_data;
                CFG_THUMB_WAIT: r_thumb_wait <= i_cfg_data;
                CFG_OVERLAP:    r_overlap    <= i_cfg_data;
                CFG_DEDICATED:  r_dedicated  <= i_cfg_data[0];
                CFG_US_LAYOUT:  r_us_layout  <= i_cfg_data[0];
                CFG_LEFT_ID:    r_left_id    <= i_cfg_data[IdW-1:0];
                CFG_RIGHT_ID:   r_right_id   <= i_cfg_data[IdW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_ev.ready) begin
            r_in_valid <= i_ev.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ev.valid && i_ev.ready) begin
            r_mode <= i_ev.mode;
            r_key  <= i_ev.key;
            r_now  <= i_ev.time_ms;
            r_mods <= i_ev.modifiers;
        end
    end

    // Event decode. A tick counts only as a timeout past a live deadline;
    // modes above the tick code are dropped without any effect.
    assign ev       = t_event'(r_mode);
    assign tick_hit = (ev == EV_TICK) && (r_dl != '0) && (r_now > r_dl);
    assign ev_ok    = (r_mode < ModeW'(EV_TICK)) || tick_hit;

    // Press-to-press gap (t1) and time since the later press (t2), both
    // with wrapping arithmetic.
    assign t1       = (r_phase == PH_CHAR_THUMB) ? (r_ttime - r_ctime) : (r_ctime - r_ttime);
    assign ref_time = (r_phase == PH_CHAR_THUMB) ? r_ttime : r_ctime;
    assign t2       = r_now - ref_time;
    assign t1_lt_t2 = t1 < t2;
    assign split_ok = (t2 < {{(TimeW-WaitW){1'b0}}, r_overlap}) && !t1_lt_t2;

    // Output decision: which stroke, if any, this event releases.
    always_comb begin
        emit_sel = EM_NONE;
        if (ev_ok) begin
            case (r_phase)
                PH_CHAR: begin
                    case (ev)
                        EV_ALLOFF, EV_TICK, EV_CHAR: emit_sel = EM_FULL;
                        EV_RELEASE: emit_sel = (r_key == r_pc) ? EM_FULL : EM_NONE;
                        default: emit_sel = EM_NONE;
                    endcase
                end
                PH_THUMB: begin
                    case (ev)
                        EV_ALLOFF, EV_THUMB: emit_sel = EM_FULL;
                        EV_RELEASE: emit_sel = (r_key == r_pt) ? EM_FULL : EM_NONE;
                        EV_TICK:    emit_sel = r_dedicated ? EM_NONE : EM_LONG;
                        default: emit_sel = EM_NONE;
                    endcase
                end
                PH_CHAR_THUMB: begin
                    case (ev)
                        EV_CHAR:    emit_sel = t1_lt_t2 ? EM_FULL : EM_NO_THUMB;
                        EV_RELEASE: emit_sel = (r_key == r_pc && split_ok) ? EM_NO_THUMB
                                                                           : EM_FULL;
                        EV_THUMB, EV_ALLOFF, EV_TICK: emit_sel = EM_FULL;
                        default: emit_sel = EM_NONE;
                    endcase
                end
                PH_THUMB_CHAR: begin
                    case (ev)
                        EV_THUMB:   emit_sel = t1_lt_t2 ? EM_FULL : EM_NO_CHAR;
                        EV_RELEASE: emit_sel = (r_key == r_pt && split_ok) ? EM_NO_CHAR
                                                                           : EM_FULL;
                        EV_CHAR, EV_ALLOFF, EV_TICK: emit_sel = EM_FULL;
                        default: emit_sel = EM_NONE;
                    endcase
                end
                default: emit_sel = EM_NONE;
            endcase
        end
    end

    // Result fields. A lone thumb goes out as a thumb stroke; with neither key
    // pending nothing goes out. Shift stands in for the thumb when none is held.
    assign eff_c = (emit_sel == EM_NO_CHAR)  ? '0 : r_pc;
    assign eff_t = (emit_sel == EM_NO_THUMB) ? '0 : r_pt;

    always_comb begin
        n_out_valid = 1'b0;
        n_kind      = KIND_STROKE;
        n_out_c     = '0;
        n_out_t     = r_pt;
        n_out_s     = 1'b0;
        case (emit_sel)
            EM_LONG: begin
                if (r_us_layout && r_pt[IdW-1:0] == r_left_id) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_LEFT_LONG;
                end else if (r_us_layout && r_pt[IdW-1:0] == r_right_id) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_RIGHT_LONG;
                end
            end
            EM_FULL, EM_NO_THUMB, EM_NO_CHAR: begin
                n_out_t = eff_t;
                if (eff_c == '0) begin
                    n_out_valid = (eff_t != '0);
                    n_kind      = KIND_THUMB;
                end else begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_STROKE;
                    n_out_c     = eff_c;
                    n_out_s     = ((r_mods & ShiftMask) != '0) && (eff_t == '0);
                end
            end
            default: n_out_valid = 1'b0;
        endcase
    end

    // Next phase and pending keys.
    always_comb begin
        n_phase = r_phase;
        n_pc    = r_pc;
        n_pt    = r_pt;
        n_ctime = r_ctime;
        n_ttime = r_ttime;
        n_dl    = tick_hit ? '0 : r_dl;
        if (ev_ok) begin
            case (r_phase)
                PH_IDLE: begin
                    n_pc    = '0;
                    n_pt    = '0;
                    n_ctime = '0;
                    n_ttime = '0;
                    n_dl    = '0;
                    if (ev == EV_CHAR) begin
                        n_pc    = r_key;
                        n_ctime = r_now;
                        n_dl    = r_now + TimeW'(r_char_wait);
                        n_phase = PH_CHAR;
                    end else if (ev == EV_THUMB) begin
                        n_pt    = r_key;
                        n_ttime = r_now;
                        n_dl    = r_now + TimeW'(r_thumb_wait);
                        n_phase = PH_THUMB;
                    end
                end
                PH_CHAR: begin
                    case (ev)
                        EV_INIT: n_phase = PH_IDLE;
                        EV_ALLOFF, EV_TICK: begin
                            n_pc    = '0;
                            n_pt    = '0;
                            n_phase = PH_IDLE;
                        end
                        EV_CHAR: begin
                            n_pt    = '0;
                            n_pc    = r_key;
                            n_ctime = r_now;
                            n_dl    = r_now + TimeW'(r_char_wait);
                        end
                        EV_THUMB: begin
                            n_pt    = r_key;
                            n_ttime = r_now;
                            n_dl    = r_now + TimeW'(r_thumb_wait);
                            n_phase = PH_CHAR_THUMB;
                        end
                        EV_RELEASE: begin
                            if (r_key == r_pc) begin
                                n_pc    = '0;
                                n_pt    = '0;
                                n_phase = PH_IDLE;
                            end
                        end
                        default: ;
                    endcase
                end
                PH_THUMB: begin
                    case (ev)
                        EV_INIT: n_phase = PH_IDLE;
                        EV_ALLOFF: begin
                            n_pc    = '0;
                            n_pt    = '0;
                            n_phase = PH_IDLE;
                        end
                        EV_CHAR: begin
                            n_pc    = r_key;
                            n_ctime = r_now;
                            n_dl    = r_now + TimeW'(r_char_wait);
                            n_phase = PH_THUMB_CHAR;
                        end
                        EV_THUMB: begin
                            n_pc    = '0;
                            n_pt    = r_key;
                            n_ttime = r_now;
                            n_dl    = r_now + TimeW'(r_thumb_wait);
                        end
                        EV_RELEASE: begin
                            if (r_key == r_pt) begin
                                n_pc    = '0;
                                n_pt    = '0;
                                n_phase = PH_IDLE;
                            end
                        end
                        EV_TICK: begin
                            if (!r_dedicated) begin
                                n_pc    = '0;
                                n_pt    = '0;
                                n_phase = PH_IDLE;
                            end
                        end
                        default: ;
                    endcase
                end
                PH_CHAR_THUMB: begin
                    case (ev)
                        EV_INIT: n_phase = PH_IDLE;
                        EV_CHAR: begin
                            n_pc    = r_key;
                            n_ctime = r_now;
                            n_dl    = r_now + TimeW'(r_char_wait);
                            if (t1_lt_t2) begin
                                n_pt    = '0;
                                n_phase = PH_CHAR;
                            end else begin
                                n_phase = PH_THUMB_CHAR;
                            end
                        end
                        EV_THUMB: begin
                            n_pc    = '0;
                            n_pt    = r_key;
                            n_ttime = r_now;
                            n_dl    = r_now + TimeW'(r_thumb_wait);
                            n_phase = PH_THUMB;
                        end
                        EV_RELEASE: begin
                            n_pc = '0;
                            if (r_key == r_pc && split_ok) begin
                                n_phase = PH_THUMB;
                            end else begin
                                n_pt    = '0;
                                n_phase = PH_IDLE;
                            end
                        end
                        default: begin
                            n_pc    = '0;
                            n_pt    = '0;
                            n_phase = PH_IDLE;
                        end
                    endcase
                end
                PH_THUMB_CHAR: begin
                    case (ev)
                        EV_INIT: n_phase = PH_IDLE;
                        EV_CHAR: begin
                            n_pt    = '0;
                            n_pc    = r_key;
                            n_ctime = r_now;
                            n_dl    = r_now + TimeW'(r_char_wait);
                            n_phase = PH_CHAR;
                        end
                        EV_THUMB: begin
                            n_pt    = r_key;
                            n_ttime = r_now;
                            n_dl    = r_now + TimeW'(r_thumb_wait);
                            if (t1_lt_t2) begin
                                n_pc    = '0;
                                n_phase = PH_THUMB;
                            end else begin
                                n_phase = PH_CHAR_THUMB;
                            end
                        end
                        EV_RELEASE: begin
                            n_pt = '0;
                            if (r_key == r_pt && split_ok) begin
                                n_phase = PH_CHAR;
                            end else begin
                                n_pc    = '0;
                                n_phase = PH_IDLE;
                            end
                        end
                        default: begin
                            n_pc    = '0;
                            n_pt    = '0;
                            n_phase = PH_IDLE;
                        end
                    endcase
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pc    <= '0;
            r_pt    <= '0;
            r_ctime <= '0;
            r_ttime <= '0;
            r_dl    <= '0;
        end else if (fire) begin
            r_phase <= n_phase;
            r_pc    <= n_pc;
            r_pt    <= n_pt;
            r_ctime <= n_ctime;
            r_ttime <= n_ttime;
            r_dl    <= n_dl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= n_out_valid;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && n_out_valid) begin
            r_kind     <= n_kind;
            r_out_c    <= n_out_c;
            r_out_t    <= n_out_t;
            r_out_s    <= n_out_s;
            r_out_mods <= r_mods;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.kind           = r_kind;
    assign o_res.char_key       = r_out_c;
    assign o_res.thumb_key      = r_out_t;
    assign o_res.shift_as_thumb = r_out_s;
    assign o_res.held_modifiers = r_out_mods;

endmodule

### design/tscd_checker.sv
// Port-level checks for the thumb-shift chord detector, bound to the top level.
// Depends on tscd_pkg and thumb_shift_chord_detector.
module tscd_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [tscd_pkg::KindW-1:0]   i_kind,
    input logic [tscd_pkg::KeyW-1:0]    i_char_key,
    input logic [tscd_pkg::KeyW-1:0]    i_thumb_key,
    input logic                         i_shift
);
    import tscd_pkg::*;

    // A stalled result keeps its kind and keys until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_char_key)
            && $stable(i_thumb_key) && $stable(i_kind))
        else $error("stalled result changed");

    // Only an ordinary stroke carries a character key, and it always has one.
    a_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_kind == KIND_STROKE) == (i_char_key != '0)))
        else $error("character key does not match the result kind");

    // A lone thumb stroke always names its thumb key.
    a_thumb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == KIND_THUMB |-> i_thumb_key != '0)
        else $error("thumb stroke without a thumb key");

    // Shift stands in only for a missing thumb on a character stroke.
    a_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_shift |-> i_kind == KIND_STROKE && i_thumb_key == '0)
        else $error("shift substitution with a thumb key present");

endmodule

bind thumb_shift_chord_detector tscd_checker u_tscd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_kind      (o_res.kind),
    .i_char_key  (o_res.char_key),
    .i_thumb_key (o_res.thumb_key),
    .i_shift     (o_res.shift_as_thumb)
);

### sim/thumb_shift_chord_detector_test.sv
// Self-checking bench for thumb_shift_chord_detector: event driver, stroke monitor, predictor.
// Depends on tscd_pkg, tscd_in_if, tscd_out_if and the detector itself.
`timescale 1ns / 1ps

module thumb_shift_chord_detector_test;
    import tscd_pkg::*;

    // The two mode codes that the block must ignore without touching its state.
    localparam logic [ModeW-1:0] MODE_SPARE_A = 3'd6;
    localparam logic [ModeW-1:0] MODE_SPARE_B = 3'd7;

    // Cycles with no transfer on either channel before the run is declared hung.
    localparam int QuietLimit = 2000;
    // Margin after the queues drain, for events still passing through the block's registers.
    localparam int SettleCycles = 8;

    typedef struct packed {
        logic [ModeW-1:0] mode;
        logic [KeyW-1:0]  key;
        logic [TimeW-1:0] time_ms;
        logic [ModW-1:0]  modifiers;
    } key_event_t;

    typedef struct packed {
        t_kind            kind;
        logic [KeyW-1:0]  char_key;
        logic [KeyW-1:0]  thumb_key;
        logic             shift_as_thumb;
        logic [ModW-1:0]  held_modifiers;
    } stroke_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    t_cfg_idx i_cfg_idx;
    logic [CfgDataW-1:0] i_cfg_data;

    tscd_in_if  key_ev ();
    tscd_out_if stroke_out ();

    thumb_shift_chord_detector DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ev       (key_ev),
        .o_res      (stroke_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Stimulus waiting to be offered, and strokes the predictor says must come out.
    key_event_t events_to_send[$];
    stroke_t    strokes_due[$];

    int  faults = 0;
    int  quiet_cycles = 0;
    bit  ev_taken = 1'b0;     // the event on the channel was transferred at the last edge
    bit  steady = 1'b0;       // when set, neither side inserts idle cycles
    logic [TimeW-1:0] now_ms = '0;
    logic [KeyW-1:0]  last_char = '0;
    logic [KeyW-1:0]  last_thumb = '0;

    // Mirror of the configuration registers, starting from their reset values.
    logic [WaitW-1:0] cfg_char_wait = 10'd100;
    logic [WaitW-1:0] cfg_thumb_wait = 10'd100;
    logic [WaitW-1:0] cfg_overlap = 10'd50;
    logic             cfg_dedicated = 1'b0;
    logic             cfg_us_layout = 1'b0;
    logic [IdW-1:0]   cfg_left_id = '0;
    logic [IdW-1:0]   cfg_right_id = '0;

    // Predictor state: the phase of the chord machine, the keys held back and their times.
    t_phase           kb_phase = PH_IDLE;
    logic [KeyW-1:0]  held_char = '0;
    logic [KeyW-1:0]  held_thumb = '0;
    logic [TimeW-1:0] char_down_ms = '0;
    logic [TimeW-1:0] thumb_down_ms = '0;
    logic [TimeW-1:0] expiry_ms = '0;     // zero means no timeout is armed

    function automatic void arm_char(input logic [KeyW-1:0] k, input logic [TimeW-1:0] at);
        held_char = k;
        char_down_ms = at;
        expiry_ms = at + TimeW'(cfg_char_wait);
    endfunction

    function automatic void arm_thumb(input logic [KeyW-1:0] k, input logic [TimeW-1:0] at);
        held_thumb = k;
        thumb_down_ms = at;
        expiry_ms = at + TimeW'(cfg_thumb_wait);
    endfunction

    // Builds the stroke from whatever is held and clears both keys. A lone thumb goes out
    // as such; otherwise shift stands in for a missing thumb, and no character means no stroke.
    function automatic bit form_stroke(input logic [ModW-1:0] mods, output stroke_t s);
        s = '0;
        s.held_modifiers = mods;
        if (held_char == '0 && held_thumb != '0) begin
            s.kind = KIND_THUMB;
            s.thumb_key = held_thumb;
            held_thumb = '0;
            return 1'b1;
        end
        s.kind = KIND_STROKE;
        s.char_key = held_char;
        s.thumb_key = held_thumb;
        s.shift_as_thumb = ((mods & ShiftMask) != '0) && (held_thumb == '0);
        held_char = '0;
        held_thumb = '0;
        return s.char_key != '0;
    endfunction

    // Advances the chord machine by one event; returns 1 when a stroke comes out.
    function automatic bit detect_chord(input key_event_t e, output stroke_t s);
        t_event ev;
        logic [TimeW-1:0] t1, t2;
        logic [KeyW-1:0] keep;
        bit got;
        got = 1'b0;
        s = '0;
        if (e.mode == EV_TICK) begin
            // A tick only counts once the armed deadline has strictly passed.
            if (expiry_ms == '0 || !(e.time_ms > expiry_ms))
                return 1'b0;
            expiry_ms = '0;
        end else if (e.mode > EV_TICK) begin
            return 1'b0;
        end
        ev = t_event'(e.mode);

        case (kb_phase)
            PH_IDLE: begin
                expiry_ms = '0;
                char_down_ms = '0;
                thumb_down_ms = '0;
                held_char = '0;
                held_thumb = '0;
                if (ev == EV_CHAR) begin
                    arm_char(e.key, e.time_ms);
                    kb_phase = PH_CHAR;
                end else if (ev == EV_THUMB) begin
                    arm_thumb(e.key, e.time_ms);
                    kb_phase = PH_THUMB;
                end
            end
            PH_CHAR: begin
                case (ev)
                    EV_INIT: kb_phase = PH_IDLE;
                    EV_ALLOFF, EV_TICK: begin
                        got = form_stroke(e.modifiers, s);
                        kb_phase = PH_IDLE;
                    end
                    EV_CHAR: begin
                        got = form_stroke(e.modifiers, s);
                        arm_char(e.key, e.time_ms);
                    end
                    EV_THUMB: begin
                        arm_thumb(e.key, e.time_ms);
                        kb_phase = PH_CHAR_THUMB;
                    end
                    default: begin
                        if (e.key == held_char) begin
                            got = form_stroke(e.modifiers, s);
                            kb_phase = PH_IDLE;
                        end
                    end
                endcase
            end
            PH_THUMB: begin
                case (ev)
                    EV_INIT: kb_phase = PH_IDLE;
                    EV_ALLOFF: begin
                        got = form_stroke(e.modifiers, s);
                        kb_phase = PH_IDLE;
                    end
                    EV_CHAR: begin
                        arm_char(e.key, e.time_ms);
                        kb_phase = PH_THUMB_CHAR;
                    end
                    EV_THUMB: begin
                        got = form_stroke(e.modifiers, s);
                        arm_thumb(e.key, e.time_ms);
                    end
                    EV_RELEASE: begin
                        if (e.key == held_thumb) begin
                            got = form_stroke(e.modifiers, s);
                            kb_phase = PH_IDLE;
                        end
                    end
                    default: begin
                        // Thumb held past its wait: a long press, reported only outside dedicated mode, on the
                        // US layout and only for the two configured thumb codes.
                        if (!cfg_dedicated) begin
                            s.thumb_key = held_thumb;
                            s.held_modifiers = e.modifiers;
                            if (cfg_us_layout && held_thumb[7:0] == cfg_left_id) begin
                                s.kind = KIND_LEFT_LONG;
                                got = 1'b1;
                            end else if (cfg_us_layout && held_thumb[7:0] == cfg_right_id) begin
                                s.kind = KIND_RIGHT_LONG;
                                got = 1'b1;
                            end
                            held_char = '0;
                            held_thumb = '0;
                            kb_phase = PH_IDLE;
                        end
                    end
                endcase
            end
            PH_CHAR_THUMB: begin
                t1 = thumb_down_ms - char_down_ms;
                t2 = e.time_ms - thumb_down_ms;
                case (ev)
                    EV_INIT: kb_phase = PH_IDLE;
                    EV_CHAR: begin
                        if (t1 < t2) begin
                            got = form_stroke(e.modifiers, s);
                            arm_char(e.key, e.time_ms);
                            kb_phase = PH_CHAR;
                        end else begin
                            // The thumb belongs with the new character, not the old one.
                            keep = held_thumb;
                            held_thumb = '0;
                            got = form_stroke(e.modifiers, s);
                            held_thumb = keep;
                            arm_char(e.key, e.time_ms);
                            kb_phase = PH_THUMB_CHAR;
                        end
                    end
                    EV_THUMB: begin
                        got = form_stroke(e.modifiers, s);
                        arm_thumb(e.key, e.time_ms);
                        kb_phase = PH_THUMB;
                    end
                    EV_RELEASE: begin
                        if (e.key == held_char && t2 < cfg_overlap && t1 >= t2) begin
                            keep = held_thumb;
                            held_thumb = '0;
                            got = form_stroke(e.modifiers, s);
                            held_char = '0;
                            held_thumb = keep;
                            kb_phase = PH_THUMB;
                        end else begin
                            got = form_stroke(e.modifiers, s);
                            kb_phase = PH_IDLE;
                        end
                    end
                    default: begin
                        got = form_stroke(e.modifiers, s);
                        kb_phase = PH_IDLE;
                    end
                endcase
            end
            PH_THUMB_CHAR: begin
                t1 = char_down_ms - thumb_down_ms;
                t2 = e.time_ms - char_down_ms;
                case (ev)
                    EV_INIT: kb_phase = PH_IDLE;
                    EV_CHAR: begin
                        got = form_stroke(e.modifiers, s);
                        arm_char(e.key, e.time_ms);
                        kb_phase = PH_CHAR;
                    end
                    EV_THUMB: begin
                        if (t1 < t2) begin
                            got = form_stroke(e.modifiers, s);
                            arm_thumb(e.key, e.time_ms);
                            kb_phase = PH_THUMB;
                        end else begin
                            keep = held_char;
                            held_char = '0;
                            got = form_stroke(e.modifiers, s);
                            held_char = keep;
                            arm_thumb(e.key, e.time_ms);
                            kb_phase = PH_CHAR_THUMB;
                        end
                    end
                    EV_RELEASE: begin
                        if (e.key == held_thumb && t2 < cfg_overlap && t1 >= t2) begin
                            keep = held_char;
                            held_char = '0;
                            got = form_stroke(e.modifiers, s);
                            held_char = keep;
                            kb_phase = PH_CHAR;
                        end else begin
                            got = form_stroke(e.modifiers, s);
                            kb_phase = PH_IDLE;
                        end
                    end
                    default: begin
                        got = form_stroke(e.modifiers, s);
                        kb_phase = PH_IDLE;
                    end
                endcase
            end
            default: kb_phase = PH_IDLE;
        endcase
        return got;
    endfunction

    function automatic void note_fault(input string msg);
        if (faults < 10)
            $display("%0t: %s", $realtime, msg);
        faults++;
    endfunction

    // Event driver. A held event stays on the channel untouched until its transfer;
    // otherwise the head of the queue is offered, unless this cycle is an idle one.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            key_ev.valid <= 1'b0;
        end else if (key_ev.valid && !ev_taken) begin
            // Still waiting for ready: keep valid and payload as they are.
        end else if (events_to_send.size() != 0 && (steady || $urandom_range(99) >= 33)) begin
            key_ev.valid     <= 1'b1;
            key_ev.mode      <= events_to_send[0].mode;
            key_ev.key       <= events_to_send[0].key;
            key_ev.time_ms   <= events_to_send[0].time_ms;
            key_ev.modifiers <= events_to_send[0].modifiers;
        end else begin
            key_ev.valid <= 1'b0;
        end
    end

    // The stroke side stalls on its own random schedule.
    always @(negedge i_clk) begin
        stroke_out.ready <= i_rst_n && (steady || $urandom_range(99) >= 33);
    end

    // At each rising edge: run the predictor on a transferred event, then check a
    // transferred stroke against the oldest one still due.
    always @(posedge i_clk) begin
        key_event_t taken;
        stroke_t    want;
        stroke_t    seen;
        if (i_rst_n && key_ev.valid && key_ev.ready) begin
            taken.mode = key_ev.mode;
            taken.key = key_ev.key;
            taken.time_ms = key_ev.time_ms;
            taken.modifiers = key_ev.modifiers;
            if (detect_chord(taken, want))
                strokes_due.push_back(want);
            void'(events_to_send.pop_front());
        end
        if (i_rst_n && stroke_out.valid && stroke_out.ready) begin
            seen.kind = t_kind'(stroke_out.kind);
            seen.char_key = stroke_out.char_key;
            seen.thumb_key = stroke_out.thumb_key;
            seen.shift_as_thumb = stroke_out.shift_as_thumb;
            seen.held_modifiers = stroke_out.held_modifiers;
            if (strokes_due.size() == 0) begin
                note_fault($sformatf("unexpected stroke: kind %0d char %h thumb %h shift %0d mods %h",
                           seen.kind, seen.char_key, seen.thumb_key, seen.shift_as_thumb,
                           seen.held_modifiers));
            end else begin
                want = strokes_due.pop_front();
                if (seen !== want)
                    note_fault($sformatf({"stroke mismatch: expected kind %0d char %h thumb %h ",
                               "shift %0d mods %h, got kind %0d char %h thumb %h shift %0d mods %h"},
                               want.kind, want.char_key, want.thumb_key, want.shift_as_thumb,
                               want.held_modifiers, seen.kind, seen.char_key, seen.thumb_key,
                               seen.shift_as_thumb, seen.held_modifiers));
            end
        end
        ev_taken <= i_rst_n && key_ev.valid && key_ev.ready;
    end

    // Watchdog: a long run of cycles with no transfer at all means the block has hung.
    always @(posedge i_clk) begin
        if ((key_ev.valid && key_ev.ready) || (stroke_out.valid && stroke_out.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QuietLimit) begin
            $display("** thumb_shift_chord_detector: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_event(input logic [ModeW-1:0] mode, input logic [KeyW-1:0] k,
                               input logic [TimeW-1:0] at, input logic [ModW-1:0] mods);
        key_event_t e;
        e.mode = mode;
        e.key = k;
        e.time_ms = at;
        e.modifiers = mods;
        events_to_send.push_back(e);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CfgDataW-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_CHAR_WAIT:  cfg_char_wait = val;
            CFG_THUMB_WAIT: cfg_thumb_wait = val;
            CFG_OVERLAP:    cfg_overlap = val;
            CFG_DEDICATED:  cfg_dedicated = val[0];
            CFG_US_LAYOUT:  cfg_us_layout = val[0];
            CFG_LEFT_ID:    cfg_left_id = val[IdW-1:0];
            CFG_RIGHT_ID:   cfg_right_id = val[IdW-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_settings(input int char_wait, input int thumb_wait, input int overlap,
                                  input bit dedicated, input bit us_layout,
                                  input logic [IdW-1:0] left_id, input logic [IdW-1:0] right_id);
        write_reg(CFG_CHAR_WAIT, CfgDataW'(char_wait));
        write_reg(CFG_THUMB_WAIT, CfgDataW'(thumb_wait));
        write_reg(CFG_OVERLAP, CfgDataW'(overlap));
        write_reg(CFG_DEDICATED, CfgDataW'(dedicated));
        write_reg(CFG_US_LAYOUT, CfgDataW'(us_layout));
        write_reg(CFG_LEFT_ID, CfgDataW'(left_id));
        write_reg(CFG_RIGHT_ID, CfgDataW'(right_id));
    endtask

    // Waits until every queued event has been transferred and every predicted stroke
    // has arrived, then lets events that cause no stroke finish inside the block.
    task automatic settle();
        while (events_to_send.size() != 0 || strokes_due.size() != 0)
            @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // Random typing. Release events usually name the last character or thumb key pressed, so the
    // chord phases get exercised; time steps mostly stay within the configured waits.
    task automatic random_keystrokes(input int count);
        int made;
        int roll;
        int pick;
        int span;
        logic [ModeW-1:0] md;
        logic [KeyW-1:0]  k;
        logic [ModW-1:0]  m;
        made = 0;
        span = int'(cfg_char_wait);
        if (int'(cfg_thumb_wait) > span) span = int'(cfg_thumb_wait);
        if (int'(cfg_overlap) > span) span = int'(cfg_overlap);
        span = span + 2;
        while (made < count) begin
            pick = $urandom_range(99);
            if (pick < 45)
                now_ms = now_ms + TimeW'($urandom_range(0, 20));
            else if (pick < 90)
                now_ms = now_ms + TimeW'($urandom_range(0, span));
            else if (pick < 98)
                now_ms = now_ms + TimeW'($urandom_range(0, 3 * span));
            else
                now_ms = now_ms + TimeW'($urandom());

            pick = $urandom_range(99);
            if (pick < 40)
                m = '0;
            else if (pick < 70)
                m = ModW'($urandom());
            else
                m = ($urandom_range(1) ? 8'h02 : 8'h20) | (ModW'($urandom()) & ~ShiftMask);

            k = KeyW'($urandom());
            roll = $urandom_range(99);
            if (roll < 27) begin
                md = EV_CHAR;
                if ($urandom_range(19) == 0)
                    k = '0;
                last_char = k;
            end else if (roll < 47) begin
                md = EV_THUMB;
                pick = $urandom_range(99);
                if (pick < 35)
                    k[7:0] = cfg_left_id;
                else if (pick < 70)
                    k[7:0] = cfg_right_id;
                last_thumb = k;
            end else if (roll < 67) begin
                md = EV_RELEASE;
                pick = $urandom_range(99);
                if (pick < 40)
                    k = last_char;
                else if (pick < 80)
                    k = last_thumb;
            end else if (roll < 91) begin
                md = EV_TICK;
            end else if (roll < 94) begin
                md = EV_ALLOFF;
            end else if (roll < 97) begin
                md = EV_INIT;
            end else begin
                md = $urandom_range(1) ? MODE_SPARE_A : MODE_SPARE_B;
            end
            queue_event(md, k, now_ms, m);
            if (md <= EV_TICK)
                made++;
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_CHAR_WAIT;
        i_cfg_data = '0;
        key_ev.valid = 1'b0;
        key_ev.mode = EV_INIT;
        key_ev.key = '0;
        key_ev.time_ms = '0;
        key_ev.modifiers = '0;
        stroke_out.ready = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed sequence on the reset settings: waits of 100 ms, overlap of 50 ms.
        // A tick with no deadline armed does nothing.
        queue_event(EV_TICK, 16'hFFFF, 32'd0, 8'hFF);
        // Lone character: the tick exactly on the deadline is too early, the next one
        // times out, and held shift stands in for the thumb.
        queue_event(EV_CHAR, 16'h0041, 32'd1000, 8'h00);
        queue_event(EV_TICK, 16'h0000, 32'd1100, 8'h00);
        queue_event(EV_TICK, 16'h0000, 32'd1101, 8'h02);
        // Thumb then character, thumb released early: the thumb goes out alone and the
        // character stays pending until all keys are off.
        queue_event(EV_THUMB, 16'h1234, 32'd2000, 8'h00);
        queue_event(EV_CHAR, 16'h0042, 32'd2010, 8'h00);
        queue_event(EV_RELEASE, 16'h1234, 32'd2020, 8'h00);
        queue_event(EV_ALLOFF, 16'h0000, 32'd2030, 8'h20);
        // Character then thumb, character released early: split, then a release of an
        // unrelated key is ignored, then the thumb times out with no long-press output.
        queue_event(EV_CHAR, 16'h0043, 32'd3000, 8'h00);
        queue_event(EV_THUMB, 16'h2200, 32'd3010, 8'h00);
        queue_event(EV_RELEASE, 16'h0043, 32'd3020, 8'h00);
        queue_event(EV_RELEASE, 16'h7777, 32'd3030, 8'h00);
        queue_event(EV_TICK, 16'h0000, 32'd3200, 8'h00);
        // Init from a busy phase drops back to idle; the next event clears the keys.
        queue_event(EV_CHAR, 16'h0044, 32'd4000, 8'h00);
        queue_event(EV_INIT, 16'h0000, 32'd4001, 8'h00);
        queue_event(EV_ALLOFF, 16'h0000, 32'd4002, 8'h00);
        queue_event(MODE_SPARE_A, 16'h0044, 32'd4003, 8'h00);
        queue_event(MODE_SPARE_B, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
        // A pending character code of zero yields no stroke, even with shift held.
        queue_event(EV_CHAR, 16'h0000, 32'd5000, 8'h00);
        queue_event(EV_ALLOFF, 16'h0000, 32'd5001, 8'h22);
        // Timestamps wrapping through zero while keys overlap.
        queue_event(EV_CHAR, 16'hFFFF, 32'hFFFF_FFC0, 8'h00);
        queue_event(EV_THUMB, 16'h00FF, 32'hFFFF_FFF0, 8'h00);
        queue_event(EV_CHAR, 16'h0045, 32'h0000_0010, 8'h00);
        // A deadline that wraps to exactly zero is treated as no deadline at all.
        queue_event(EV_CHAR, 16'h0046, 32'hFFFF_FF9C, 8'h00);
        queue_event(EV_TICK, 16'h0000, 32'hFFFF_FFFF, 8'h00);
        queue_event(EV_RELEASE, 16'h0046, 32'hFFFF_FFFF, 8'hFF);
        now_ms = $urandom();
        random_keystrokes(120);
        settle();

        // Zero waits, US layout, both thumbs on the same code: left takes precedence.
        apply_settings(0, 0, 0, 1'b0, 1'b1, 8'h55, 8'h55);
        now_ms = $urandom();
        queue_event(EV_THUMB, 16'h8055, now_ms, 8'h00);
        queue_event(EV_TICK, 16'h0000, now_ms + 32'd1, 8'h11);
        random_keystrokes(140);
        settle();

        // Waits at the top of the random range with long-press output disabled; no idle cycles on either side.
        steady = 1'b1;
        apply_settings(1000, 1000, 1000, 1'b1, 1'b1, 8'hFF, 8'h00);
        now_ms = $urandom();
        random_keystrokes(140);
        settle();
        steady = 1'b0;

        // Random waits from zero up to that same top value, with long presses reported.
        apply_settings($urandom_range(0, 1000), $urandom_range(0, 1000), $urandom_range(0, 1000),
                       1'b0, 1'b1, 8'($urandom()), 8'($urandom()));
        now_ms = $urandom();
        random_keystrokes(150);
        settle();

        // Short random waits, every setting random.
        apply_settings($urandom_range(0, 200), $urandom_range(0, 200), $urandom_range(0, 200),
                       1'($urandom()), 1'($urandom()), 8'($urandom()), 8'($urandom()));
        now_ms = $urandom();
        random_keystrokes(150);
        settle();

        if (strokes_due.size() != 0)
            note_fault($sformatf("%0d predicted strokes never arrived", strokes_due.size()));
        if (faults == 0)
            $display("** thumb_shift_chord_detector: PASSED **");
        else
            $display("** thumb_shift_chord_detector: FAILED **");
        $finish;
    end

endmodule
